// File: design/srdt_pkg.sv
// Shared types, constants and codes for the scan result dedup table.
// Depends on nothing; the top, srdt_ctrl and srdt_dp refer to it by scoped names.
`default_nettype none

package srdt_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int GEN_W       = 64;
    localparam int BSSID_W     = 48;
    localparam int SLOT_W      = 5;
    localparam int TOTAL_W     = 6;

    localparam logic [7:0] MAX_SSID_BYTES = 8'd32;
    localparam logic [7:0] MAX_SECURITY   = 8'd3;
    localparam logic [7:0] MAX_BAND       = 8'd1;

    typedef enum logic [1:0] {
        CMD_BEGIN  = 2'd0,
        CMD_ACCEPT = 2'd1,
        CMD_FREEZE = 2'd2,
        CMD_CANCEL = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_STALE   = 3'd2,
        ST_PHASE   = 3'd3,
        ST_IGNORED = 3'd4,
        ST_FULL    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_COLLECTING = 2'd1,
        PH_FROZEN     = 2'd2,
        PH_CANCELLED  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_CHECK  = 2'd1,
        S_SCAN   = 2'd2,
        S_COMMIT = 2'd3
    } state_t;

    typedef struct packed {
        cmd_t                command;
        logic [GEN_W-1:0]    generation;
        logic [BSSID_W-1:0]  bssid;
        logic [7:0]          rssi;
        logic [7:0]          ssid_bytes;
        logic [7:0]          security;
        logic [7:0]          band;
        logic [7:0]          channel;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [SLOT_W-1:0]    slot;
        logic                 store_payload;
        logic [TOTAL_W-1:0]   entry_total;
        logic                 overflowed;
        phase_t               phase;
    } rsp_t;

    typedef struct packed {
        logic [BSSID_W-1:0]  bssid;
        logic [7:0]          rssi;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic need_scan;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

// File: design/scan_result_dedup_table_top.sv
// Top level of the scan result dedup table: controller plus datapath.
// Depends on srdt_pkg, srdt_ctrl, srdt_dp and srdt_ram.
//
// Usage:
//   The req channel (req_valid, req_stall, req) carries one command request:
//   begin, accept, freeze or cancel, with its generation and record fields.
//   The rsp channel (rsp_valid, rsp_stall, rsp) returns exactly one result
//   per request: status, slot, store_payload, entry_total, overflowed, phase.
//   When store_payload is set, write the SSID and payload into an external
//   memory at slot.
//   Begin, freeze, cancel and refused requests go from the check state straight
//   to commit. An accept that reaches the table scans the stored entries one
//   per cycle through the entry RAM read port, stopping at a BSSID match, and
//   then commits; at commit the result is loaded into the output register.
//   req_stall is low again the cycle after the result is loaded, and a new
//   request is taken while the previous result still waits in the output register.
//   A stalled result holds; the block then waits before loading the next one.
//   Reset empties the table, zeroes the session number and returns the phase
//   to idle; no clearing pass is needed.
`default_nettype none

module scan_result_dedup_table_top (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_stall,
    input  wire srdt_pkg::req_t  req,
    output logic                 rsp_valid,
    input  wire logic            rsp_stall,
    output srdt_pkg::rsp_t       rsp
);

    srdt_pkg::dp_cmd_t  dp_cmd;
    srdt_pkg::dp_stat_t dp_stat;

    srdt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    srdt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request taken while previous one still in work");

    a_store_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.store_payload) |-> (rsp.status == srdt_pkg::ST_OK))
        else $error("payload store with failing status");

    a_full_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == srdt_pkg::ST_FULL) |->
            (rsp.overflowed && rsp.entry_total ==
             srdt_pkg::TOTAL_W'(srdt_pkg::TABLE_DEPTH)))
        else $error("full result without truncation or full table");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.entry_total <= srdt_pkg::TOTAL_W'(srdt_pkg::TABLE_DEPTH)))
        else $error("entry total beyond table depth");

endmodule

`default_nettype wire

// File: design/srdt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module srdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: design/srdt_ctrl.sv
// Sequencing state machine: request load, session check, table scan, commit.
// Depends on srdt_pkg.
`default_nettype none

module srdt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire srdt_pkg::dp_stat_t stat,
    output srdt_pkg::dp_cmd_t       cmd
);

    srdt_pkg::state_t state_reg;
    srdt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srdt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = (state_reg != srdt_pkg::S_IDLE);
        case (state_reg)
            srdt_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = srdt_pkg::S_CHECK;
                end
            end
            srdt_pkg::S_CHECK:
            begin
                if (stat.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = srdt_pkg::S_SCAN;
                end
                else
                begin
                    state_next = srdt_pkg::S_COMMIT;
                end
            end
            srdt_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = srdt_pkg::S_COMMIT;
                end
            end
            srdt_pkg::S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = srdt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = srdt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/srdt_dp.sv
// Datapath: session registers, request checks, key scan over the entry RAM,
// table update and the result register. Depends on srdt_pkg and srdt_ram.
`default_nettype none

module srdt_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire srdt_pkg::req_t     req,
    input  wire srdt_pkg::dp_cmd_t  cmd,
    output srdt_pkg::dp_stat_t      stat,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output srdt_pkg::rsp_t          rsp
);

    srdt_pkg::req_t                   req_reg;
    srdt_pkg::phase_t                 phase_reg;
    srdt_pkg::phase_t                 phase_next;
    logic [srdt_pkg::GEN_W-1:0]       sess_reg;
    logic [srdt_pkg::GEN_W-1:0]       sess_next;
    logic [srdt_pkg::CNT_W-1:0]       count_reg;
    logic [srdt_pkg::CNT_W-1:0]       count_next;
    logic                             trunc_reg;
    logic                             trunc_next;

    logic [srdt_pkg::CNT_W-1:0]       idx_reg;
    logic [srdt_pkg::CNT_W-1:0]       idx_next;
    logic                             pend_reg;
    logic                             pend_next;
    logic                             hit_reg;
    logic                             hit_next;
    logic [srdt_pkg::IDX_W-1:0]       pidx_reg;
    logic [srdt_pkg::IDX_W-1:0]       hit_idx_reg;
    logic                             stronger_reg;

    logic                             rsp_valid_reg;
    logic                             rsp_valid_next;
    srdt_pkg::rsp_t                   rsp_reg;
    srdt_pkg::rsp_t                   rsp_next;

    srdt_pkg::status_t                pre_status;
    logic                             gen_zero;
    logic                             collecting;
    logic                             rec_bad;
    logic                             need_scan;
    logic                             scan_done;
    logic                             out_free;

    logic [srdt_pkg::ENTRY_W-1:0]     rd_data;
    srdt_pkg::entry_t                 rd_entry;
    srdt_pkg::entry_t                 wr_entry;
    logic                             cmp_hit;
    logic                             issue;

    logic                             wr_req;
    logic [srdt_pkg::IDX_W-1:0]       wr_addr;
    logic [srdt_pkg::IDX_W-1:0]       slot_idx;
    srdt_pkg::status_t                status_new;

    srdt_ram #(
        .WIDTH (srdt_pkg::ENTRY_W),
        .DEPTH (srdt_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (cmd.commit && wr_req),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (idx_reg[srdt_pkg::IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign rd_entry = rd_data;

    // session and record checks
    always_comb
    begin
        gen_zero   = (req_reg.generation == '0);
        collecting = (phase_reg == srdt_pkg::PH_COLLECTING);
        rec_bad    = (req_reg.ssid_bytes > srdt_pkg::MAX_SSID_BYTES) ||
                     (req_reg.security > srdt_pkg::MAX_SECURITY) ||
                     (req_reg.band > srdt_pkg::MAX_BAND) ||
                     (req_reg.channel == '0);
        case (req_reg.command)
            srdt_pkg::CMD_BEGIN:
            begin
                if (gen_zero)
                    pre_status = srdt_pkg::ST_INVALID;
                else if (collecting)
                    pre_status = srdt_pkg::ST_PHASE;
                else if (req_reg.generation <= sess_reg)
                    pre_status = srdt_pkg::ST_STALE;
                else
                    pre_status = srdt_pkg::ST_OK;
            end
            default:
            begin
                if (gen_zero)
                    pre_status = srdt_pkg::ST_INVALID;
                else if (req_reg.generation != sess_reg)
                    pre_status = srdt_pkg::ST_STALE;
                else if (!collecting)
                    pre_status = srdt_pkg::ST_PHASE;
                else if (req_reg.command == srdt_pkg::CMD_ACCEPT && rec_bad)
                    pre_status = srdt_pkg::ST_INVALID;
                else
                    pre_status = srdt_pkg::ST_OK;
            end
        endcase
        need_scan = (pre_status == srdt_pkg::ST_OK) &&
                    (req_reg.command == srdt_pkg::CMD_ACCEPT);
    end

    // key scan: one read issued per cycle, each compared in the next cycle
    assign cmp_hit   = pend_reg && (rd_entry.bssid == req_reg.bssid);
    assign issue     = cmd.scan && !cmp_hit && (idx_reg != count_reg);
    assign scan_done = cmp_hit || (!pend_reg && (idx_reg == count_reg));
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign stat      = {need_scan, scan_done, out_free};

    always_comb
    begin
        idx_next  = idx_reg;
        pend_next = pend_reg;
        hit_next  = hit_reg;
        if (cmd.scan_start)
        begin
            idx_next  = '0;
            pend_next = 1'b0;
            hit_next  = 1'b0;
        end
        else if (cmd.scan)
        begin
            pend_next = issue;
            if (issue)
                idx_next = idx_reg + srdt_pkg::CNT_W'(1);
            if (cmp_hit)
                hit_next = 1'b1;
        end
    end

    // table update and result
    always_comb
    begin
        phase_next     = phase_reg;
        sess_next      = sess_reg;
        count_next     = count_reg;
        trunc_next     = trunc_reg;
        wr_req         = 1'b0;
        wr_addr        = hit_idx_reg;
        slot_idx       = '0;
        status_new     = pre_status;
        wr_entry.bssid = req_reg.bssid;
        wr_entry.rssi  = req_reg.rssi;
        if (pre_status == srdt_pkg::ST_OK)
        begin
            case (req_reg.command)
                srdt_pkg::CMD_BEGIN:
                begin
                    count_next = '0;
                    trunc_next = 1'b0;
                    sess_next  = req_reg.generation;
                    phase_next = srdt_pkg::PH_COLLECTING;
                end
                srdt_pkg::CMD_FREEZE:
                begin
                    phase_next = srdt_pkg::PH_FROZEN;
                end
                srdt_pkg::CMD_CANCEL:
                begin
                    count_next = '0;
                    trunc_next = 1'b0;
                    phase_next = srdt_pkg::PH_CANCELLED;
                end
                srdt_pkg::CMD_ACCEPT:
                begin
                    if (hit_reg)
                    begin
                        if (stronger_reg)
                        begin
                            wr_req   = 1'b1;
                            wr_addr  = hit_idx_reg;
                            slot_idx = hit_idx_reg;
                        end
                        else
                        begin
                            status_new = srdt_pkg::ST_IGNORED;
                        end
                    end
                    else if (count_reg == srdt_pkg::CNT_W'(srdt_pkg::TABLE_DEPTH))
                    begin
                        trunc_next = 1'b1;
                        status_new = srdt_pkg::ST_FULL;
                    end
                    else
                    begin
                        wr_req     = 1'b1;
                        wr_addr    = count_reg[srdt_pkg::IDX_W-1:0];
                        slot_idx   = count_reg[srdt_pkg::IDX_W-1:0];
                        count_next = count_reg + srdt_pkg::CNT_W'(1);
                    end
                end
                default:
                begin
                    status_new = pre_status;
                end
            endcase
        end
        rsp_next.status        = status_new;
        rsp_next.slot          = srdt_pkg::SLOT_W'(slot_idx);
        rsp_next.store_payload = wr_req;
        rsp_next.entry_total   = srdt_pkg::TOTAL_W'(count_next);
        rsp_next.overflowed    = trunc_next;
        rsp_next.phase         = phase_next;

        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= srdt_pkg::PH_IDLE;
            sess_reg      <= '0;
            count_reg     <= '0;
            trunc_reg     <= 1'b0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                phase_reg <= phase_next;
                sess_reg  <= sess_next;
                count_reg <= count_next;
                trunc_reg <= trunc_next;
            end
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (issue)
            pidx_reg <= idx_reg[srdt_pkg::IDX_W-1:0];
        if (cmd.scan && cmp_hit)
        begin
            hit_idx_reg  <= pidx_reg;
            stronger_reg <= ($signed(req_reg.rssi) > $signed(rd_entry.rssi));
        end
        if (cmd.commit)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
